@@ rtl/core/owm_pkg.sv @@
package owm_pkg;

  localparam int unsigned TimeW      = 10;
  localparam int unsigned CfgIndexW  = 3;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [2:0] {
    CmdTick      = 3'd0,
    CmdReset     = 3'd1,
    CmdWriteBit  = 3'd2,
    CmdReadBit   = 3'd3,
    CmdWriteByte = 3'd4,
    CmdReadByte  = 3'd5
  } command_e;

  typedef enum logic [CfgIndexW-1:0] {
    RegResetLowTime    = 3'd0,
    RegPresenceWait    = 3'd1,
    RegResetRecover    = 3'd2,
    RegSlotLength      = 3'd3,
    RegWriteOneLow     = 3'd4,
    RegWriteZeroLow    = 3'd5,
    RegReadLowTime     = 3'd6,
    RegReadSampleDelay = 3'd7
  } cfg_index_e;

  localparam logic [TimeW-1:0] DefResetLowTime    = 10'd480;
  localparam logic [TimeW-1:0] DefPresenceWait    = 10'd70;
  localparam logic [TimeW-1:0] DefResetRecover    = 10'd410;
  localparam logic [TimeW-1:0] DefSlotLength      = 10'd70;
  localparam logic [TimeW-1:0] DefWriteOneLow     = 10'd6;
  localparam logic [TimeW-1:0] DefWriteZeroLow    = 10'd60;
  localparam logic [TimeW-1:0] DefReadLowTime     = 10'd6;
  localparam logic [TimeW-1:0] DefReadSampleDelay = 10'd9;

  // Decoded tick as it travels from the front to the back
  typedef struct packed {
    logic       is_op;
    logic       is_rst;
    logic       is_read;
    logic       is_byte;
    logic [7:0] wdata;
    logic       line;
  } item_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy;
    logic       done;
    logic       presence;
    logic [7:0] read_data;
    logic       refused;
  } res_t;

endpackage

@@ rtl/core/owm_fifo.sv @@
module owm_fifo #(
  parameter int unsigned DEPTH = owm_pkg::QueueDepth,
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + CntW'(1);
      2'b01:   count_d = count_q - CntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ rtl/core/owm_front.sv @@
module owm_front #(
  parameter int unsigned QUEUE_DEPTH = owm_pkg::QueueDepth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  logic [2:0]           command_i,
  input  logic [7:0]           write_data_i,
  input  logic                 line_level_i,
  output owm_pkg::item_t       item_o,
  output logic                 item_empty_o,
  input  logic                 item_pop_i
);

  owm_pkg::item_t item;
  logic [$bits(owm_pkg::item_t)-1:0] item_bits;

  // Classify the command once so the back only sees what it acts on
  always_comb begin
    item.is_op   = command_i inside {owm_pkg::CmdReset, owm_pkg::CmdWriteBit,
                                     owm_pkg::CmdReadBit, owm_pkg::CmdWriteByte,
                                     owm_pkg::CmdReadByte};
    item.is_rst  = (command_i == owm_pkg::CmdReset);
    item.is_read = command_i inside {owm_pkg::CmdReadBit, owm_pkg::CmdReadByte};
    item.is_byte = command_i inside {owm_pkg::CmdWriteByte, owm_pkg::CmdReadByte};
    if (item.is_read) begin
      item.wdata = '0;
    end else if (item.is_byte) begin
      item.wdata = write_data_i;
    end else begin
      item.wdata = {7'b0, write_data_i[0]};
    end
    item.line = line_level_i;
  end

  owm_fifo #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH ($bits(owm_pkg::item_t))
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (item),
    .full_o  (full),
    .pop_i   (item_pop_i),
    .data_o  (item_bits),
    .empty_o (item_empty_o)
  );

  assign item_o = owm_pkg::item_t'(item_bits);

endmodule

@@ rtl/core/owm_back.sv @@
module owm_back #(
  parameter int unsigned QUEUE_DEPTH = owm_pkg::QueueDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  owm_pkg::item_t               item_i,
  input  logic                         item_empty_i,
  output logic                         item_pop_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [owm_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [owm_pkg::TimeW-1:0]    cfg_data_i,
  output owm_pkg::res_t                res_o,
  output logic                         empty,
  input  logic                         pop
);

  localparam int unsigned TW = owm_pkg::TimeW;

  localparam logic [2:0] PhIdle       = 3'd0;
  localparam logic [2:0] PhRstLow     = 3'd1;
  localparam logic [2:0] PhRstWait    = 3'd2;
  localparam logic [2:0] PhRstRecover = 3'd3;
  localparam logic [2:0] PhSlot       = 3'd4;

  logic [TW-1:0] rst_low_q, pres_wait_q, rst_rec_q, slot_len_q;
  logic [TW-1:0] w1_low_q, w0_low_q, rd_low_q, rd_delay_q;

  logic [2:0]    phase_q, phase_d;
  logic [TW-1:0] tc_q, tc_d;
  logic [2:0]    bit_q, bit_d;
  logic [7:0]    shift_q, shift_d;
  logic          byte_q, byte_d;
  logic          read_q, read_d;
  logic          pres_q, pres_d;

  logic [TW-1:0] last, low;
  logic [TW:0]   sample_sum;
  logic [TW-1:0] sample_at;
  logic          res_full, step;
  owm_pkg::res_t res;
  logic [$bits(owm_pkg::res_t)-1:0] res_bits;

  assign step        = !item_empty_i && !res_full;
  assign item_pop_o  = step;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    phase_d = phase_q;
    tc_d    = tc_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    byte_d  = byte_q;
    read_d  = read_q;
    pres_d  = pres_q;
    res     = '0;
    last    = '0;
    low     = '0;
    sample_sum = '0;
    sample_at  = '0;

    // Start a new operation, or refuse the request while one runs
    if (phase_q == PhIdle) begin
      if (item_i.is_op) begin
        tc_d  = '0;
        bit_d = '0;
        if (item_i.is_rst) begin
          phase_d = PhRstLow;
          pres_d  = 1'b0;
        end else begin
          phase_d = PhSlot;
          read_d  = item_i.is_read;
          byte_d  = item_i.is_byte;
          shift_d = item_i.wdata;
        end
      end
    end else begin
      res.refused = item_i.is_op;
    end

    case (phase_d)
      PhIdle: begin
      end
      PhRstLow: begin
        res.drive_low = 1'b1;
        tc_d = tc_d + TW'(1);
        if (tc_d >= rst_low_q) begin
          phase_d = PhRstWait;
          tc_d    = '0;
        end
      end
      PhRstWait: begin
        if (tc_d >= pres_wait_q) begin
          pres_d = !item_i.line;
          tc_d   = '0;
          if (rst_rec_q == '0) begin
            phase_d  = PhIdle;
            res.done = 1'b1;
          end else begin
            phase_d = PhRstRecover;
          end
        end else begin
          tc_d = tc_d + TW'(1);
        end
      end
      PhRstRecover: begin
        tc_d = tc_d + TW'(1);
        if (tc_d >= rst_rec_q) begin
          phase_d  = PhIdle;
          tc_d     = '0;
          res.done = 1'b1;
        end
      end
      PhSlot: begin
        last = (slot_len_q == '0) ? '0 : slot_len_q - TW'(1);
        if (read_d) begin
          low = rd_low_q;
        end else begin
          low = shift_d[0] ? w1_low_q : w0_low_q;
        end
        res.drive_low = (tc_d < low);
        // Clamp the read sample to the last tick of the slot
        sample_sum = {1'b0, low} + {1'b0, rd_delay_q};
        sample_at  = (sample_sum > {1'b0, last}) ? last : sample_sum[TW-1:0];
        if (read_d && (tc_d == sample_at)) begin
          shift_d = {item_i.line, shift_d[7:1]};
        end
        if (tc_d >= last) begin
          if (!read_d) begin
            shift_d = {1'b0, shift_d[7:1]};
          end
          tc_d = '0;
          if (byte_d && (bit_d != 3'd7)) begin
            bit_d = bit_d + 3'd1;
          end else begin
            phase_d  = PhIdle;
            bit_d    = '0;
            res.done = 1'b1;
            if (read_d) begin
              res.read_data = byte_d ? shift_d : {7'b0, shift_d[7]};
            end
          end
        end else begin
          tc_d = tc_d + TW'(1);
        end
      end
      default: begin
        phase_d = PhIdle;
      end
    endcase

    res.busy     = (phase_d != PhIdle);
    res.presence = pres_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      tc_q    <= '0;
      bit_q   <= '0;
      shift_q <= '0;
      byte_q  <= 1'b0;
      read_q  <= 1'b0;
      pres_q  <= 1'b0;
    end else if (step) begin
      phase_q <= phase_d;
      tc_q    <= tc_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      byte_q  <= byte_d;
      read_q  <= read_d;
      pres_q  <= pres_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rst_low_q  <= owm_pkg::DefResetLowTime;
      pres_wait_q <= owm_pkg::DefPresenceWait;
      rst_rec_q  <= owm_pkg::DefResetRecover;
      slot_len_q <= owm_pkg::DefSlotLength;
      w1_low_q   <= owm_pkg::DefWriteOneLow;
      w0_low_q   <= owm_pkg::DefWriteZeroLow;
      rd_low_q   <= owm_pkg::DefReadLowTime;
      rd_delay_q <= owm_pkg::DefReadSampleDelay;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        owm_pkg::RegResetLowTime:    rst_low_q   <= cfg_data_i;
        owm_pkg::RegPresenceWait:    pres_wait_q <= cfg_data_i;
        owm_pkg::RegResetRecover:    rst_rec_q   <= cfg_data_i;
        owm_pkg::RegSlotLength:      slot_len_q  <= cfg_data_i;
        owm_pkg::RegWriteOneLow:     w1_low_q    <= cfg_data_i;
        owm_pkg::RegWriteZeroLow:    w0_low_q    <= cfg_data_i;
        owm_pkg::RegReadLowTime:     rd_low_q    <= cfg_data_i;
        owm_pkg::RegReadSampleDelay: rd_delay_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  owm_fifo #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH ($bits(owm_pkg::res_t))
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (step),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_bits),
    .empty_o (empty)
  );

  assign res_o = owm_pkg::res_t'(res_bits);

endmodule

@@ rtl/core/one_wire_master_timing_core.sv @@
// 1-Wire bus master, one microsecond tick per request.
// Each tick taken steps the bit-timing state machine once; results go to a result queue.
// Throughput: one tick per cycle while a tick is queued and the result queue has room.
// Each side has a QUEUE_DEPTH entry queue, so either side may stall on its own.
// Reset (rst_ni low, asynchronous): queues empty, bus idle, timing registers at defaults.
module one_wire_master_timing_core #(
  parameter int unsigned QUEUE_DEPTH = owm_pkg::QueueDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [2:0]                    command_i,
  input  logic [7:0]                    write_data_i,
  input  logic                          line_level_i,
  output logic                          empty,
  input  logic                          pop,
  output logic                          drive_low_o,
  output logic                          busy_res_o,
  output logic                          done_res_o,
  output logic                          presence_o,
  output logic [7:0]                    read_data_o,
  output logic                          refused_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [owm_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [owm_pkg::TimeW-1:0]     cfg_data_i
);

  owm_pkg::item_t item;
  owm_pkg::res_t  res;
  logic           item_empty, item_pop;

  owm_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .command_i    (command_i),
    .write_data_i (write_data_i),
    .line_level_i (line_level_i),
    .item_o       (item),
    .item_empty_o (item_empty),
    .item_pop_i   (item_pop)
  );

  owm_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_empty_i (item_empty),
    .item_pop_o   (item_pop),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .res_o        (res),
    .empty        (empty),
    .pop          (pop)
  );

  assign drive_low_o = res.drive_low;
  assign busy_res_o  = res.busy;
  assign done_res_o  = res.done;
  assign presence_o  = res.presence;
  assign read_data_o = res.read_data;
  assign refused_o   = res.refused;

endmodule
